// ===== design/ffdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ffdt_pkg
// Shared constants, codes and types of the frame feedback displace trail unit.
// ----------------------------------------------------------------------------
package ffdt_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_SHIFT  = 4096;

    localparam int CFG_DW = 14;
    localparam int CFG_IW = 3;
    localparam int DIM_RW = 9;
    localparam int SHF_RW = 14;
    localparam int WGT_W  = 9;
    localparam int Q_DEPTH = 2;

    localparam logic [WGT_W-1:0] WGT_FULL = 9'd256;

    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SHIFT_X      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SHIFT_Y      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_MIX_WEIGHT   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_EDGE_MODE    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_COMBINE_MODE = 3'd6;

    typedef enum logic [1:0] {
        EDGE_WRAP  = 2'd0,
        EDGE_CLAMP = 2'd1,
        EDGE_ZERO  = 2'd2
    } t_edge;

    localparam logic COMB_BLEND = 1'b0;
    localparam logic COMB_TRAIL = 1'b1;

    typedef struct packed {
        logic [3:0][7:0]  pixel;
        logic             used;
        logic             last;
        logic             present;
        logic             bank;
        logic             combine;
        logic [WGT_W-1:0] weight;
    } t_job;

endpackage

// ===== design/ffdt_queue.sv =====
// ----------------------------------------------------------------------------
// ffdt_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module ffdt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTW = (ffdt_pkg::Q_DEPTH > 1) ? $clog2(ffdt_pkg::Q_DEPTH) : 1;
    localparam int CNW = $clog2(ffdt_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [ffdt_pkg::Q_DEPTH];
    logic [PTW-1:0]   r_wr_ptr;
    logic [PTW-1:0]   r_rd_ptr;
    logic [CNW-1:0]   r_count;

    assign o_full  = (r_count == CNW'(ffdt_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTW'(ffdt_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTW'(ffdt_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue pushed while full");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(ffdt_pkg::Q_DEPTH)) else $error("queue count out of range");

endmodule

// ===== design/ffdt_front.sv =====
// ----------------------------------------------------------------------------
// ffdt_front
// Accepts pixels, tracks the raster position and frame history, and maps the
// displaced source coordinate with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module ffdt_front #(
    parameter int MAX_WIDTH  = ffdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffdt_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SHIFT  = ffdt_pkg::DEF_MAX_SHIFT,
    parameter int AW         = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [3:0][7:0]              i_pixel,
    input  logic [ffdt_pkg::DIM_RW-1:0]  i_frame_width,
    input  logic [ffdt_pkg::DIM_RW-1:0]  i_frame_height,
    input  logic [ffdt_pkg::SHF_RW-1:0]  i_shift_x,
    input  logic [ffdt_pkg::SHF_RW-1:0]  i_shift_y,
    input  logic [ffdt_pkg::WGT_W-1:0]   i_mix_weight,
    input  logic [1:0]                   i_edge_mode,
    input  logic                         i_combine_mode,
    output logic                         o_push,
    output ffdt_pkg::t_job               o_job,
    output logic [AW-1:0]                o_rd_addr,
    output logic [AW-1:0]                o_wr_addr,
    input  logic                         i_full
);
    localparam int DWW  = $clog2(MAX_WIDTH + 1);
    localparam int DWH  = $clog2(MAX_HEIGHT + 1);
    localparam int CWX  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CWY  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMX  = (CWX > CWY) ? CWX : CWY;
    localparam int PW   = ((CMX > ffdt_pkg::SHF_RW) ? CMX : ffdt_pkg::SHF_RW) + 2;
    localparam int MW   = PW - 1;
    localparam int SW   = (MW > 1) ? $clog2(MW) : 1;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_state;

    t_state                r_state;
    logic [CWX-1:0]        r_col;
    logic [CWY-1:0]        r_row;
    logic [DWW-1:0]        r_act_w;
    logic [DWH-1:0]        r_act_h;
    logic [DWW-1:0]        r_hist_w;
    logic [DWH-1:0]        r_hist_h;
    logic                  r_hist_valid;
    logic                  r_hist_bank;
    ffdt_pkg::t_job        r_job;
    logic signed [PW-1:0]  r_pos_x;
    logic signed [PW-1:0]  r_pos_y;
    logic [MW-1:0]         r_mag_x;
    logic [MW-1:0]         r_mag_y;
    logic [DWW-1:0]        r_rem_x;
    logic [DWH-1:0]        r_rem_y;
    logic [SW-1:0]         r_step;
    logic [AW-1:0]         r_wr_addr;

    logic                  accept;
    logic                  first_px;
    logic [DWW-1:0]        n_act_w;
    logic [DWH-1:0]        n_act_h;
    logic                  used;
    logic                  col_end;
    logic                  row_end;
    logic signed [PW-1:0]  n_pos_x;
    logic signed [PW-1:0]  n_pos_y;
    logic [ffdt_pkg::WGT_W-1:0] weight;
    logic [DWW:0]          trial_x;
    logic [DWH:0]          trial_y;
    logic                  ok_x;
    logic                  ok_y;
    logic [AW-1:0]         rd_addr;

    assign o_in_stall = (r_state != F_IDLE);
    assign accept     = i_in_valid && (r_state == F_IDLE);
    assign first_px   = (r_col == '0) && (r_row == '0);

    always_comb begin
        int fw;
        int fh;
        int shx;
        int shy;
        fw  = int'(i_frame_width);
        fh  = int'(i_frame_height);
        shx = int'($signed(i_shift_x));
        shy = int'($signed(i_shift_y));
        if (fw == 0) fw = 1;
        if (fw > MAX_WIDTH) fw = MAX_WIDTH;
        if (fh == 0) fh = 1;
        if (fh > MAX_HEIGHT) fh = MAX_HEIGHT;
        if (shx > MAX_SHIFT) shx = MAX_SHIFT;
        if (shx < -MAX_SHIFT) shx = -MAX_SHIFT;
        if (shy > MAX_SHIFT) shy = MAX_SHIFT;
        if (shy < -MAX_SHIFT) shy = -MAX_SHIFT;
        n_act_w = first_px ? DWW'(fw) : r_act_w;
        n_act_h = first_px ? DWH'(fh) : r_act_h;
        n_pos_x = PW'(int'(r_col) - shx);
        n_pos_y = PW'(int'(r_row) - shy);
        used    = r_hist_valid && (r_hist_w == n_act_w) && (r_hist_h == n_act_h);
        col_end = (int'(r_col) + 1) >= int'(n_act_w);
        row_end = (int'(r_row) + 1) >= int'(n_act_h);
        weight  = (i_mix_weight > ffdt_pkg::WGT_FULL) ? ffdt_pkg::WGT_FULL : i_mix_weight;
        trial_x = {r_rem_x, r_mag_x[MW-1]};
        trial_y = {r_rem_y, r_mag_y[MW-1]};
    end

    always_comb begin
        int px;
        int py;
        int wx;
        int hy;
        int sx;
        int sy;
        px = int'(r_pos_x);
        py = int'(r_pos_y);
        wx = int'(r_act_w);
        hy = int'(r_act_h);
        sx = px;
        sy = py;
        ok_x = 1'b1;
        ok_y = 1'b1;
        unique case (ffdt_pkg::t_edge'(i_edge_mode))
            ffdt_pkg::EDGE_WRAP: begin
                sx = (px < 0 && r_rem_x != '0) ? wx - int'(r_rem_x) : int'(r_rem_x);
                sy = (py < 0 && r_rem_y != '0) ? hy - int'(r_rem_y) : int'(r_rem_y);
            end
            ffdt_pkg::EDGE_CLAMP: begin
                sx = (px < 0) ? 0 : ((px >= wx) ? wx - 1 : px);
                sy = (py < 0) ? 0 : ((py >= hy) ? hy - 1 : py);
            end
            default: begin
                ok_x = (px >= 0) && (px < wx);
                ok_y = (py >= 0) && (py < hy);
                if (!ok_x) sx = 0;
                if (!ok_y) sy = 0;
            end
        endcase
        rd_addr = AW'(sy * MAX_WIDTH + sx);
    end

    always_comb begin
        o_job         = r_job;
        o_job.present = ok_x && ok_y;
    end

    assign o_push    = (r_state == F_PUSH) && !i_full;
    assign o_rd_addr = rd_addr;
    assign o_wr_addr = r_wr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_act_w      <= DWW'(1);
            r_act_h      <= DWH'(1);
            r_hist_w     <= '0;
            r_hist_h     <= '0;
            r_hist_valid <= 1'b0;
            r_hist_bank  <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_act_w         <= n_act_w;
                        r_act_h         <= n_act_h;
                        r_job.pixel     <= i_pixel;
                        r_job.used      <= used;
                        r_job.last      <= col_end && row_end;
                        r_job.present   <= 1'b0;
                        r_job.bank      <= r_hist_bank;
                        r_job.combine   <= i_combine_mode;
                        r_job.weight    <= weight;
                        r_wr_addr       <= AW'(int'(r_row) * MAX_WIDTH + int'(r_col));
                        r_pos_x         <= n_pos_x;
                        r_pos_y         <= n_pos_y;
                        r_mag_x         <= n_pos_x[PW-1] ? MW'(-n_pos_x) : MW'(n_pos_x);
                        r_mag_y         <= n_pos_y[PW-1] ? MW'(-n_pos_y) : MW'(n_pos_y);
                        r_rem_x         <= '0;
                        r_rem_y         <= '0;
                        r_step          <= SW'(MW - 1);
                        r_state         <= F_DIV;
                        if (col_end) begin
                            r_col <= '0;
                            if (row_end) begin
                                r_row        <= '0;
                                r_hist_bank  <= !r_hist_bank;
                                r_hist_valid <= 1'b1;
                                r_hist_w     <= n_act_w;
                                r_hist_h     <= n_act_h;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                F_DIV: begin
                    r_rem_x <= (trial_x >= {1'b0, r_act_w}) ?
                               DWW'(trial_x - {1'b0, r_act_w}) : DWW'(trial_x);
                    r_rem_y <= (trial_y >= {1'b0, r_act_h}) ?
                               DWH'(trial_y - {1'b0, r_act_h}) : DWH'(trial_y);
                    r_mag_x <= r_mag_x << 1;
                    r_mag_y <= r_mag_y << 1;
                    r_step  <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== design/ffdt_back.sv =====
// ----------------------------------------------------------------------------
// ffdt_back
// Reads the history word from the ping-pong frame store, combines it with the
// current pixel, writes the result back and holds it in the output register.
// ----------------------------------------------------------------------------
module ffdt_back #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  ffdt_pkg::t_job  i_job,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic [AW-1:0]   i_wr_addr,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [3:0][7:0] o_pixel,
    output logic            o_history_used,
    output logic            o_frame_last
);
    typedef enum logic {B_IDLE, B_CALC} t_state;

    logic [31:0]     r_mem [2 * DEPTH];
    t_state          r_state;
    ffdt_pkg::t_job  r_job;
    logic [AW-1:0]   r_wr_addr;
    logic [31:0]     r_rd_data;
    logic            r_out_valid;
    logic [3:0][7:0] r_out_pixel;
    logic            r_out_used;
    logic            r_out_last;

    logic            load;
    logic [31:0]     word;
    logic [3:0][7:0] result;

    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign load  = (r_state == B_CALC) && (!r_out_valid || !i_out_stall);
    assign word  = r_job.present ? r_rd_data : 32'd0;

    always_comb begin
        logic [17:0] blend;
        logic [17:0] faded;
        logic [7:0]  prev;
        logic [7:0]  cur;
        for (int c = 0; c < 4; c++) begin
            prev  = word[8*c +: 8];
            cur   = r_job.pixel[c];
            blend = 18'(cur) * 18'(ffdt_pkg::WGT_FULL - r_job.weight)
                  + 18'(prev) * 18'(r_job.weight) + 18'd128;
            faded = 18'(prev) * 18'(r_job.weight) + 18'd128;
            if (!r_job.used) begin
                result[c] = cur;
            end else if (r_job.combine == ffdt_pkg::COMB_TRAIL) begin
                result[c] = (cur > faded[15:8]) ? cur : faded[15:8];
            end else begin
                result[c] = blend[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[{i_job.bank, i_rd_addr}];
        end
        if (load) begin
            r_mem[{!r_job.bank, r_wr_addr}] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job     <= i_job;
                        r_wr_addr <= i_wr_addr;
                        r_state   <= B_CALC;
                    end
                end
                B_CALC: begin
                    if (load) begin
                        r_out_pixel <= result;
                        r_out_used  <= r_job.used;
                        r_out_last  <= r_job.last;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel        = r_out_pixel;
    assign o_history_used = r_out_used;
    assign o_frame_last   = r_out_last;

endmodule

// ===== design/frame_feedback_displace_trail_unit.sv =====
// ----------------------------------------------------------------------------
// frame_feedback_displace_trail_unit
// Video feedback trail: blends or trails each pixel with a displaced copy of
// the previous output frame held in ping-pong frame stores.
// ----------------------------------------------------------------------------
// Each pixel word is accepted, then the front part runs a bit-serial
// remainder for the wrapped source coordinate over the PW-1 bits of its
// magnitude (PW is two more than the wider of the shift and counter widths)
// and then queues the job, stalling while the queue is full; input stalls
// until the job is queued. The back part reads the store, combines and
// writes back while the front part works on the next word. The frame stores
// need no clearing after reset: history is used only once a whole frame of
// matching size has been written.
module frame_feedback_displace_trail_unit #(
    parameter int MAX_WIDTH  = ffdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffdt_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SHIFT  = ffdt_pkg::DEF_MAX_SHIFT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ffdt_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [ffdt_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_red_in,
    input  logic [7:0]                   i_green_in,
    input  logic [7:0]                   i_blue_in,
    input  logic [7:0]                   i_alpha_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out,
    output logic [7:0]                   o_alpha_out,
    output logic                         o_history_used,
    output logic                         o_frame_last
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = $bits(ffdt_pkg::t_job) + 2 * AW;

    logic [ffdt_pkg::DIM_RW-1:0] r_frame_width;
    logic [ffdt_pkg::DIM_RW-1:0] r_frame_height;
    logic [ffdt_pkg::SHF_RW-1:0] r_shift_x;
    logic [ffdt_pkg::SHF_RW-1:0] r_shift_y;
    logic [ffdt_pkg::WGT_W-1:0]  r_mix_weight;
    logic [1:0]                  r_edge_mode;
    logic                        r_combine_mode;

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    ffdt_pkg::t_job  f_job;
    ffdt_pkg::t_job  b_job;
    logic [AW-1:0]   f_rd_addr;
    logic [AW-1:0]   f_wr_addr;
    logic [AW-1:0]   b_rd_addr;
    logic [AW-1:0]   b_wr_addr;
    logic [QW-1:0]   q_out;
    logic [3:0][7:0] in_pixel;
    logic [3:0][7:0] out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
            r_shift_x      <= '0;
            r_shift_y      <= '0;
            r_mix_weight   <= '0;
            r_edge_mode    <= ffdt_pkg::EDGE_WRAP;
            r_combine_mode <= ffdt_pkg::COMB_BLEND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ffdt_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[8:0];
                ffdt_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[8:0];
                ffdt_pkg::REG_SHIFT_X:      r_shift_x      <= i_cfg_data;
                ffdt_pkg::REG_SHIFT_Y:      r_shift_y      <= i_cfg_data;
                ffdt_pkg::REG_MIX_WEIGHT:   r_mix_weight   <= i_cfg_data[8:0];
                ffdt_pkg::REG_EDGE_MODE:    r_edge_mode    <= i_cfg_data[1:0];
                ffdt_pkg::REG_COMBINE_MODE: r_combine_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_pixel = {i_alpha_in, i_blue_in, i_green_in, i_red_in};

    ffdt_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_SHIFT (MAX_SHIFT),
        .AW        (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (in_pixel),
        .i_frame_width (r_frame_width),
        .i_frame_height(r_frame_height),
        .i_shift_x     (r_shift_x),
        .i_shift_y     (r_shift_y),
        .i_mix_weight  (r_mix_weight),
        .i_edge_mode   (r_edge_mode),
        .i_combine_mode(r_combine_mode),
        .o_push        (push),
        .o_job         (f_job),
        .o_rd_addr     (f_rd_addr),
        .o_wr_addr     (f_wr_addr),
        .i_full        (full)
    );

    ffdt_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_job, f_rd_addr, f_wr_addr}),
        .o_full (full),
        .i_pop  (pop),
        .o_data (q_out),
        .o_empty(empty)
    );

    assign {b_job, b_rd_addr, b_wr_addr} = q_out;

    ffdt_back #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_job         (b_job),
        .i_rd_addr     (b_rd_addr),
        .i_wr_addr     (b_wr_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel       (out_pixel),
        .o_history_used(o_history_used),
        .o_frame_last  (o_frame_last)
    );

    assign o_red_out   = out_pixel[0];
    assign o_green_out = out_pixel[1];
    assign o_blue_out  = out_pixel[2];
    assign o_alpha_out = out_pixel[3];

endmodule
